/* rtl/core/cmp_pkg.sv */
`timescale 1ns / 1ps

package cmp_pkg;

  localparam int unsigned LINE_CAPACITY = 9;
  localparam int unsigned VALUE_CHARS   = 4;

  localparam int unsigned POS_W   = $clog2(LINE_CAPACITY + 1);
  localparam int unsigned SUM_W   = POS_W + 1;
  localparam int unsigned VALUE_W = 14;
  localparam int unsigned CHAR_W  = 8;

  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_G     = 8'h67;
  localparam logic [CHAR_W-1:0] CHAR_R     = 8'h72;
  localparam logic [CHAR_W-1:0] CHAR_X     = 8'h78;
  localparam logic [CHAR_W-1:0] CHAR_Y     = 8'h79;

  localparam logic [POS_W-1:0] HEADER_COLON_IDX = POS_W'(2);

  localparam logic [VALUE_W-1:0] RST_X = VALUE_W'(320);
  localparam logic [VALUE_W-1:0] RST_Y = VALUE_W'(240);

  typedef enum logic [1:0] {
    ST_UPDATED   = 2'd0,
    ST_IGNORED   = 2'd1,
    ST_MISPLACED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    TGT_GREEN_X = 2'd0,
    TGT_GREEN_Y = 2'd1,
    TGT_RED_X   = 2'd2,
    TGT_RED_Y   = 2'd3
  } target_e;

  typedef struct packed {
    logic               colon_seen;
    logic [POS_W-1:0]   colon_idx;
    logic [CHAR_W-1:0]  hdr_first;
    logic [CHAR_W-1:0]  hdr_second;
    logic [VALUE_W-1:0] value;
  } line_t;

endpackage

/* rtl/core/cmp_line_tracker.sv */
`timescale 1ns / 1ps

module cmp_line_tracker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic                       clear_i,
  input  logic [cmp_pkg::CHAR_W-1:0] char_i,
  output cmp_pkg::line_t             line_o
);
  import cmp_pkg::*;

  logic [POS_W-1:0]   pos_q, pos_d;
  line_t              line_q, line_d;
  logic               is_digit;
  logic               in_window;
  logic [SUM_W-1:0]   win_end;
  logic [VALUE_W-1:0] digit_val;

  assign is_digit  = (char_i >= CHAR_ZERO) && (char_i <= CHAR_NINE);
  assign win_end   = SUM_W'(line_q.colon_idx) + SUM_W'(VALUE_CHARS);
  assign in_window = (pos_q > line_q.colon_idx) && (SUM_W'(pos_q) <= win_end);
  assign digit_val = VALUE_W'(char_i - CHAR_ZERO);

  always_comb begin
    pos_d  = pos_q;
    line_d = line_q;
    if (clear_i) begin
      pos_d  = '0;
      line_d = '0;
    end else if (step_i && (pos_q < POS_W'(LINE_CAPACITY))) begin
      if (pos_q == POS_W'(0)) begin
        line_d.hdr_first = char_i;
      end else if (pos_q == POS_W'(1)) begin
        line_d.hdr_second = char_i;
      end
      if (line_q.colon_seen) begin
        if (in_window && is_digit) begin
          line_d.value = (line_q.value << 3) + (line_q.value << 1) + digit_val;
        end
      end else if (char_i == CHAR_COLON) begin
        line_d.colon_seen = 1'b1;
        line_d.colon_idx  = pos_q;
      end
      pos_d = pos_q + POS_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      line_q <= '0;
    end else begin
      pos_q  <= pos_d;
      line_q <= line_d;
    end
  end

  assign line_o = line_q;

endmodule

/* rtl/core/coordinate_message_parser.sv */
`timescale 1ns / 1ps

// Parses text lines of the form HH:VVVV, one received byte per item, and
// accepts one item every cycle. A byte is registered on input and handled from
// that register; a carriage return that closes a line holding a colon
// produces one result item with the stored green/red coordinates after that
// line. Results sit in an output register, so input keeps flowing while a
// result waits; only a line end that produces a result, arriving while the
// previous result is still held, stalls the input. A line's result passes
// through the input byte register and then the output register.
module coordinate_message_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [1:0]  target_o,
  output logic [13:0] value_o,
  output logic        frame_done_o,
  output logic [13:0] green_x_o,
  output logic [13:0] green_y_o,
  output logic [13:0] red_x_o,
  output logic [13:0] red_y_o
);
  import cmp_pkg::*;

  logic              in_valid_q;
  logic [CHAR_W-1:0] byte_q;
  line_t             line;
  logic              is_cr, produce, out_free, advance;

  logic [VALUE_W-1:0] gx_q, gy_q, rx_q, ry_q;
  logic [VALUE_W-1:0] gx_d, gy_d, rx_d, ry_d;
  status_e            status_d;
  target_e            target_d;
  logic [VALUE_W-1:0] value_d;
  logic               done_d;

  logic               out_valid_q;
  status_e            status_q;
  target_e            target_q;
  logic [VALUE_W-1:0] value_q;
  logic               done_q;
  logic [VALUE_W-1:0] ogx_q, ogy_q, orx_q, ory_q;

  assign is_cr    = (byte_q == CHAR_CR);
  assign produce  = is_cr && line.colon_seen;
  assign out_free = !out_valid_q || !out_stall_i;
  assign advance  = in_valid_q && (!produce || out_free);
  assign in_stall_o = in_valid_q && !advance;

  cmp_line_tracker u_line (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance && !is_cr),
    .clear_i (advance && is_cr),
    .char_i  (byte_q),
    .line_o  (line)
  );

  always_comb begin
    gx_d     = gx_q;
    gy_d     = gy_q;
    rx_d     = rx_q;
    ry_d     = ry_q;
    status_d = ST_MISPLACED;
    target_d = TGT_GREEN_X;
    value_d  = '0;
    done_d   = 1'b0;
    if (line.colon_idx == HEADER_COLON_IDX) begin
      value_d  = line.value;
      status_d = ST_UPDATED;
      if (line.hdr_first == CHAR_G && line.hdr_second == CHAR_X) begin
        target_d = TGT_GREEN_X;
        gx_d     = line.value;
      end else if (line.hdr_first == CHAR_G && line.hdr_second == CHAR_Y) begin
        target_d = TGT_GREEN_Y;
        gy_d     = line.value;
      end else if (line.hdr_first == CHAR_R && line.hdr_second == CHAR_X) begin
        target_d = TGT_RED_X;
        rx_d     = line.value;
      end else if (line.hdr_first == CHAR_R && line.hdr_second == CHAR_Y) begin
        target_d = TGT_RED_Y;
        ry_d     = line.value;
        done_d   = 1'b1;
      end else begin
        status_d = ST_IGNORED;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      gx_q        <= RST_X;
      gy_q        <= RST_Y;
      rx_q        <= RST_X;
      ry_q        <= RST_Y;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance && produce) begin
        out_valid_q <= 1'b1;
        gx_q        <= gx_d;
        gy_q        <= gy_d;
        rx_q        <= rx_d;
        ry_q        <= ry_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      byte_q <= rx_byte_i;
    end
    if (advance && produce) begin
      status_q <= status_d;
      target_q <= target_d;
      value_q  <= value_d;
      done_q   <= done_d;
      ogx_q    <= gx_d;
      ogy_q    <= gy_d;
      orx_q    <= rx_d;
      ory_q    <= ry_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign target_o     = target_q;
  assign value_o      = value_q;
  assign frame_done_o = done_q;
  assign green_x_o    = ogx_q;
  assign green_y_o    = ogy_q;
  assign red_x_o      = orx_q;
  assign red_y_o      = ory_q;

`ifndef NO_ASSERTIONS
  a_done_is_red_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o |->
      status_o == ST_UPDATED && target_o == TGT_RED_Y && red_y_o == value_o)
    else $error("frame_done without red y update");

  a_misplaced_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_MISPLACED |->
      value_o == '0 && target_o == TGT_GREEN_X && !frame_done_o)
    else $error("misplaced colon result carries data");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && is_cr && out_valid_q && out_stall_i)
    else $error("input stalled without a blocked line end");

  a_coords_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(advance && produce) |=> $stable(gx_q) && $stable(ry_q))
    else $error("coordinates changed without a line result");
`endif

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import cmp_pkg::*;

  typedef struct packed {
    status_e            status;
    target_e            target;
    logic [VALUE_W-1:0] value;
    logic               frame_done;
    logic [VALUE_W-1:0] green_x;
    logic [VALUE_W-1:0] green_y;
    logic [VALUE_W-1:0] red_x;
    logic [VALUE_W-1:0] red_y;
  } coord_report_t;

  // Tracks the line being received and the stored coordinates, and holds the
  // reports that closed lines are due to produce.
  class coord_scoreboard;
    coord_report_t      expected_reports[$];
    int                 errors;
    logic [3:0]         char_pos;
    logic [7:0]         hdr_first;
    logic [7:0]         hdr_second;
    logic               colon_seen;
    logic [3:0]         colon_idx;
    logic [VALUE_W-1:0] accum;
    logic [VALUE_W-1:0] green_x;
    logic [VALUE_W-1:0] green_y;
    logic [VALUE_W-1:0] red_x;
    logic [VALUE_W-1:0] red_y;

    function new();
      errors  = 0;
      green_x = RST_X;
      green_y = RST_Y;
      red_x   = RST_X;
      red_y   = RST_Y;
      clear_line();
    endfunction

    function void clear_line();
      char_pos   = '0;
      hdr_first  = '0;
      hdr_second = '0;
      colon_seen = 1'b0;
      colon_idx  = '0;
      accum      = '0;
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    task report(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function void accept_byte(input logic [7:0] c);
      coord_report_t rep;
      if (c != CHAR_CR) begin
        if (char_pos >= LINE_CAPACITY) return;
        if (char_pos == 0) hdr_first = c;
        else if (char_pos == 1) hdr_second = c;
        if (colon_seen) begin
          if (char_pos > colon_idx && char_pos <= colon_idx + VALUE_CHARS &&
              c >= CHAR_ZERO && c <= CHAR_NINE)
            accum = VALUE_W'(accum * 10 + (c - CHAR_ZERO));
        end else if (c == CHAR_COLON) begin
          colon_seen = 1'b1;
          colon_idx  = char_pos;
        end
        char_pos = char_pos + 4'd1;
        return;
      end
      if (!colon_seen) begin
        clear_line();
        return;
      end
      rep = '0;
      if (colon_idx != 2) begin
        rep.status = ST_MISPLACED;
      end else begin
        rep.value  = accum;
        rep.status = ST_UPDATED;
        if (hdr_first == CHAR_G && hdr_second == CHAR_X) begin
          rep.target = TGT_GREEN_X;
          green_x    = accum;
        end else if (hdr_first == CHAR_G && hdr_second == CHAR_Y) begin
          rep.target = TGT_GREEN_Y;
          green_y    = accum;
        end else if (hdr_first == CHAR_R && hdr_second == CHAR_X) begin
          rep.target = TGT_RED_X;
          red_x      = accum;
        end else if (hdr_first == CHAR_R && hdr_second == CHAR_Y) begin
          rep.target     = TGT_RED_Y;
          red_y          = accum;
          rep.frame_done = 1'b1;
        end else begin
          rep.status = ST_IGNORED;
        end
      end
      rep.green_x = green_x;
      rep.green_y = green_y;
      rep.red_x   = red_x;
      rep.red_y   = red_y;
      expected_reports.push_back(rep);
      clear_line();
    endfunction

    task check_field(input string name, input int got, input int want);
      if (got != want)
        report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task check_result(input coord_report_t got);
      coord_report_t want;
      if (expected_reports.size() == 0) begin
        report("result with no line pending");
        return;
      end
      want = expected_reports.pop_front();
      check_field("status", got.status, want.status);
      check_field("target", got.target, want.target);
      check_field("value", got.value, want.value);
      check_field("frame_done", got.frame_done, want.frame_done);
      check_field("green_x", got.green_x, want.green_x);
      check_field("green_y", got.green_y, want.green_y);
      check_field("red_x", got.red_x, want.red_x);
      check_field("red_y", got.red_y, want.red_y);
    endtask
  endclass

  logic               clk_i     = 1'b0;
  logic               rst_ni    = 1'b0;
  logic               in_valid  = 1'b0;
  logic [7:0]         rx_byte   = '0;
  logic               out_stall = 1'b0;
  logic               in_stall_o;
  logic               out_valid_o;
  logic [1:0]         status_o;
  logic [1:0]         target_o;
  logic [VALUE_W-1:0] value_o;
  logic               frame_done_o;
  logic [VALUE_W-1:0] green_x_o;
  logic [VALUE_W-1:0] green_y_o;
  logic [VALUE_W-1:0] red_x_o;
  logic [VALUE_W-1:0] red_y_o;

  coord_scoreboard sb = new();
  coord_report_t   seen_report;
  bit              idle_in   = 1'b0;
  bit              idle_out  = 1'b0;
  bit              hold_req  = 1'b0;
  int              bytes_sent = 0;

  coordinate_message_parser DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall_o),
    .rx_byte_i    (rx_byte),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall),
    .status_o     (status_o),
    .target_o     (target_o),
    .value_o      (value_o),
    .frame_done_o (frame_done_o),
    .green_x_o    (green_x_o),
    .green_y_o    (green_y_o),
    .red_x_o      (red_x_o),
    .red_y_o      (red_y_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      seen_report.status     = status_e'(status_o);
      seen_report.target     = target_e'(target_o);
      seen_report.value      = value_o;
      seen_report.frame_done = frame_done_o;
      seen_report.green_x    = green_x_o;
      seen_report.green_y    = green_y_o;
      seen_report.red_x      = red_x_o;
      seen_report.red_y      = red_y_o;
      sb.check_result(seen_report);
    end
  end

  function automatic logic [7:0] any_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CHAR_CR);
    return c;
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = any_char(); while (c == CHAR_COLON);
    return c;
  endfunction

  function automatic logic [7:0] digit_char();
    return CHAR_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // valid stays high across back-to-back items
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = idle_in ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk_i); while (in_stall_o);
    sb.accept_byte(b);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_byte(s[i]);
    send_byte(CHAR_CR);
  endtask

  task automatic send_random_line();
    logic [7:0] line[$];
    int         kind;
    int         cpos;
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      if ($urandom_range(0, 7) == 0) begin
        line.push_back(any_char());
        line.push_back(any_char());
      end else begin
        line.push_back($urandom_range(0, 1) ? CHAR_G : CHAR_R);
        line.push_back($urandom_range(0, 1) ? CHAR_X : CHAR_Y);
      end
      line.push_back(CHAR_COLON);
      repeat ($urandom_range(0, 9))
        line.push_back($urandom_range(0, 5) == 0 ? any_char() : digit_char());
    end else if (kind < 8) begin
      // first colon anywhere, including past the kept part of the line
      cpos = $urandom_range(0, 11);
      repeat (cpos) line.push_back(plain_char());
      line.push_back(CHAR_COLON);
      repeat ($urandom_range(0, 4)) line.push_back(digit_char());
    end else if (kind == 8) begin
      repeat ($urandom_range(0, 14)) line.push_back(plain_char());
    end else begin
      repeat ($urandom_range(1, 14)) line.push_back(8'($urandom_range(0, 255)));
    end
    if (kind != 9) line.push_back(CHAR_CR);
    foreach (line[i]) send_byte(line[i]);
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic drive_out_stall();
    int n;
    forever begin
      if (hold_req) begin
        n        = 300;
        hold_req = 1'b0;
      end else begin
        n = idle_out ? $urandom_range(0, 4) : 0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    fork
      drive_out_stall();
    join_none

    send_text("");
    send_text("gx:9999");
    send_text("ry:0");
    send_text("ab:12");
    send_text(":");
    wait_results();

    for (int ph = 0; ph < 4; ph++) begin
      idle_in  = ph[0];
      idle_out = ph[1];
      if (ph == 2) hold_req = 1'b1;
      while (bytes_sent < 22 + (ph + 1) * 325) send_random_line();
      wait_results();
    end

    repeat (8) @(posedge clk_i);
    if (sb.pending() != 0) sb.report("results never arrived");
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* files.f */
rtl/core/cmp_pkg.sv
rtl/core/cmp_line_tracker.sv
rtl/core/coordinate_message_parser.sv
bench/tb_top.sv
